// ----- rtl/sbad_pkg.sv -----
// ----------------------------------------------------------------------------
// sbad_pkg
// Shared widths, defaults and types of the stereo block average decimator.
// ----------------------------------------------------------------------------
`default_nettype none

package sbad_pkg;

   // Fixed field widths
   localparam int SAMPLE_W = 16;
   localparam int LEN_W    = 13;

   // Register reset and default capacity
   localparam int LEN_RESET                = 882;
   localparam int MAX_BLOCK_LENGTH_DEFAULT = 4096;

   typedef logic signed [SAMPLE_W-1:0] sample_type;

   // Sequencer states
   typedef enum logic [1:0] {
      ST_ACCUM,
      ST_DIVIDE,
      ST_DELIVER
   } state_type;

   // Per-lane control issued by the sequencer
   typedef struct packed {
      logic add;     // fold the sample into the running sum
      logic start;   // close the block and launch the divide
   } lane_ctl_type;

endpackage

`default_nettype wire

// ----- rtl/sbad_req_if.sv -----
// ----------------------------------------------------------------------------
// sbad_req_if
// Request channel: one stereo sample pair per transfer.
// ----------------------------------------------------------------------------
`default_nettype none

interface sbad_req_if;
   import sbad_pkg::*;

   logic       valid;
   logic       ready;
   sample_type left_sample;
   sample_type right_sample;

   modport source (output valid, output left_sample, output right_sample, input ready);
   modport sink   (input valid, input left_sample, input right_sample, output ready);
endinterface

`default_nettype wire

// ----- rtl/sbad_rsp_if.sv -----
// ----------------------------------------------------------------------------
// sbad_rsp_if
// Response channel: one pair of block averages per transfer.
// ----------------------------------------------------------------------------
`default_nettype none

interface sbad_rsp_if;
   import sbad_pkg::*;

   logic       valid;
   logic       ready;
   sample_type left_average;
   sample_type right_average;

   modport source (output valid, output left_average, output right_average, input ready);
   modport sink   (input valid, input left_average, input right_average, output ready);
endinterface

`default_nettype wire

// ----- rtl/sbad_lane.sv -----
// ----------------------------------------------------------------------------
// sbad_lane
// One channel: running sum of samples and a bit-serial restoring divider
// that turns the closed block's sum into its mean, truncated toward zero.
// ----------------------------------------------------------------------------
`default_nettype none

module sbad_lane #(
   parameter int  MAX_BLOCK_LENGTH = sbad_pkg::MAX_BLOCK_LENGTH_DEFAULT,
   localparam int CNT_W            = $clog2(MAX_BLOCK_LENGTH + 1)
) (
   input  logic                  clock,
   input  logic                  reset,
   input  sbad_pkg::lane_ctl_type ctl,
   input  sbad_pkg::sample_type  sample,
   input  logic [CNT_W-1:0]      divisor,
   output logic                  done,
   output sbad_pkg::sample_type  average
);
   import sbad_pkg::*;

   localparam int SUM_W  = SAMPLE_W + $clog2(MAX_BLOCK_LENGTH);
   localparam int STEP_W = $clog2(SUM_W + 1);

   logic signed [SUM_W-1:0] acc_ff, acc_in;
   logic                    busy_ff, busy_in;
   logic [STEP_W-1:0]       step_ff, step_in;
   logic [SUM_W-1:0]        dvd_ff, dvd_in;
   logic [CNT_W-1:0]        rem_ff, rem_in;
   logic [CNT_W-1:0]        dsr_ff, dsr_in;
   logic                    neg_ff, neg_in;

   logic signed [SUM_W-1:0] sum_new;
   logic [SUM_W-1:0]        magnitude;
   logic [CNT_W:0]          partial;
   logic [CNT_W:0]          diff;
   logic                    fits;
   logic                    last_step;
   sample_type              quotient;

   // Add the sample and take the magnitude of the closing sum
   assign sum_new   = acc_ff + SUM_W'(sample);
   assign magnitude = sum_new[SUM_W-1] ? SUM_W'(-sum_new) : SUM_W'(sum_new);

   // One restoring step: shift in the next dividend bit, try the subtract
   assign partial   = {rem_ff, dvd_ff[SUM_W-1]};
   assign diff      = partial - {1'b0, dsr_ff};
   assign fits      = ~diff[CNT_W];
   assign last_step = busy_ff && (step_ff == STEP_W'(SUM_W - 1));

   always_comb begin
      acc_in  = acc_ff;
      busy_in = busy_ff;
      step_in = step_ff;
      dvd_in  = dvd_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      neg_in  = neg_ff;
      if (ctl.start) begin
         acc_in  = '0;
         busy_in = 1'b1;
         step_in = '0;
         dvd_in  = magnitude;
         rem_in  = '0;
         dsr_in  = divisor;
         neg_in  = sum_new[SUM_W-1];
      end else begin
         if (ctl.add) begin
            acc_in = sum_new;
         end
         if (busy_ff) begin
            rem_in  = fits ? diff[CNT_W-1:0] : partial[CNT_W-1:0];
            dvd_in  = {dvd_ff[SUM_W-2:0], fits};
            step_in = step_ff + 1'b1;
            busy_in = ~last_step;
         end
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff  <= '0;
         busy_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         acc_ff  <= acc_in;
         busy_ff <= busy_in;
         step_ff <= step_in;
      end
   end

   // Divider datapath
   always_ff @(posedge clock) begin
      dvd_ff <= dvd_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
      neg_ff <= neg_in;
   end

   // Restore the sign on the low bits of the quotient
   assign quotient = dvd_ff[SAMPLE_W-1:0];
   assign average  = neg_ff ? -quotient : quotient;
   assign done     = last_step;

endmodule

`default_nettype wire

// ----- rtl/sbad_merge.sv -----
// ----------------------------------------------------------------------------
// sbad_merge
// Output register that joins the two lane averages into one response and
// holds it until the sink takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module sbad_merge (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 load,
   input  sbad_pkg::sample_type left_in,
   input  sbad_pkg::sample_type right_in,
   output logic                 free,
   sbad_rsp_if.source           rsp_bus
);
   import sbad_pkg::*;

   logic       valid_ff, valid_in;
   sample_type left_ff, right_ff;

   // Room when empty or when the held response leaves this cycle
   assign free = ~valid_ff | rsp_bus.ready;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (rsp_bus.ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Capture both averages together
   always_ff @(posedge clock) begin
      if (load) begin
         left_ff  <= left_in;
         right_ff <= right_in;
      end
   end

   assign rsp_bus.valid         = valid_ff;
   assign rsp_bus.left_average  = left_ff;
   assign rsp_bus.right_average = right_ff;

endmodule

`default_nettype wire

// ----- rtl/stereo_block_average_decimator_unit.sv -----
// ----------------------------------------------------------------------------
// stereo_block_average_decimator_unit
// Boxcar decimator for stereo PCM: averages block_length sample pairs into
// one output pair.
// ----------------------------------------------------------------------------
// A pair that does not close a block is folded into the running sums. The
// pair that closes a block is accepted, then the bit-serial restoring
// divider in each channel lane produces the quotient one bit per step, and
// the averages move into the output register once it has room. No pair is
// taken until then. Both lanes divide side by side. The output register
// holds a finished response while the next block accumulates. A block
// length of zero acts as one; lengths above MAX_BLOCK_LENGTH act as
// MAX_BLOCK_LENGTH. Writing csr_wr_data does not clear the running block.
`default_nettype none

module stereo_block_average_decimator_unit #(
   parameter int MAX_BLOCK_LENGTH = sbad_pkg::MAX_BLOCK_LENGTH_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_wr_en,
   input  logic [sbad_pkg::LEN_W-1:0] csr_wr_data,
   sbad_req_if.sink                   req_bus,
   sbad_rsp_if.source                 rsp_bus
);
   import sbad_pkg::*;

   localparam int CNT_W = $clog2(MAX_BLOCK_LENGTH + 1);
   localparam int CMP_W = (CNT_W > LEN_W) ? CNT_W : LEN_W;

   state_type         state_ff, state_in;
   logic [LEN_W-1:0]  len_ff;
   logic [CNT_W-1:0]  count_ff, count_in;

   logic [CMP_W-1:0]  eff_len;
   logic [CNT_W-1:0]  count_inc;
   logic              closing;
   logic              accept;
   logic              lane_done_l, lane_done_r;
   logic              merge_free, merge_load;
   lane_ctl_type      lane_ctl;
   sample_type        avg_l, avg_r;

   // Clamp the block length to 1..MAX_BLOCK_LENGTH
   always_comb begin
      eff_len = CMP_W'(len_ff);
      if (len_ff == '0) begin
         eff_len = CMP_W'(1);
      end else if (CMP_W'(len_ff) > CMP_W'(MAX_BLOCK_LENGTH)) begin
         eff_len = CMP_W'(MAX_BLOCK_LENGTH);
      end
   end

   assign count_inc = count_ff + 1'b1;
   assign closing   = CMP_W'(count_inc) >= eff_len;
   assign accept    = req_bus.valid & req_bus.ready;

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_ACCUM: begin
            if (accept && closing) state_in = ST_DIVIDE;
         end
         ST_DIVIDE: begin
            if (lane_done_l) state_in = ST_DELIVER;
         end
         ST_DELIVER: begin
            if (merge_free) state_in = ST_ACCUM;
         end
         default: state_in = ST_ACCUM;
      endcase
   end

   // Sequencer outputs
   always_comb begin
      req_bus.ready  = 1'b0;
      merge_load     = 1'b0;
      case (state_ff)
         ST_ACCUM:   req_bus.ready = 1'b1;
         ST_DIVIDE:  req_bus.ready = 1'b0;
         ST_DELIVER: merge_load    = merge_free;
         default:    req_bus.ready = 1'b0;
      endcase
   end

   // Fold every accepted request, close the block on the last one
   assign lane_ctl.add   = accept;
   assign lane_ctl.start = accept & closing;

   // Advance or clear the pair counter
   always_comb begin
      count_in = count_ff;
      if (accept) begin
         count_in = closing ? '0 : count_inc;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_ACCUM;
         count_ff <= '0;
         len_ff   <= LEN_W'(LEN_RESET);
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         if (csr_wr_en) begin
            len_ff <= csr_wr_data;
         end
      end
   end

   // Channel lanes
   sbad_lane #(.MAX_BLOCK_LENGTH(MAX_BLOCK_LENGTH)) u_lane_l (
      .clock   (clock),
      .reset   (reset),
      .ctl     (lane_ctl),
      .sample  (req_bus.left_sample),
      .divisor (count_inc),
      .done    (lane_done_l),
      .average (avg_l)
   );

   sbad_lane #(.MAX_BLOCK_LENGTH(MAX_BLOCK_LENGTH)) u_lane_r (
      .clock   (clock),
      .reset   (reset),
      .ctl     (lane_ctl),
      .sample  (req_bus.right_sample),
      .divisor (count_inc),
      .done    (lane_done_r),
      .average (avg_r)
   );

   // Join the lanes into one response
   sbad_merge u_merge (
      .clock    (clock),
      .reset    (reset),
      .load     (merge_load),
      .left_in  (avg_l),
      .right_in (avg_r),
      .free     (merge_free),
      .rsp_bus  (rsp_bus)
   );

   // Both lanes run the same number of divide steps
   a_lanes_in_step: assert property (@(posedge clock) disable iff (reset)
      lane_done_l == lane_done_r)
      else $error("lane divide completion out of step");

   // The counter never reaches the block capacity
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff < CNT_W'(MAX_BLOCK_LENGTH))
      else $error("pair counter beyond capacity");

   // A closing request launches a divide and stops intake
   a_close_divides: assert property (@(posedge clock) disable iff (reset)
      lane_ctl.start |=> (state_ff == ST_DIVIDE) && !req_bus.ready)
      else $error("closing request did not start the divide");

   // A loaded response shows on the output next cycle
   a_load_shows: assert property (@(posedge clock) disable iff (reset)
      merge_load |=> rsp_bus.valid)
      else $error("loaded response not presented");

endmodule

`default_nettype wire

// ----- dv/sbad_average_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbad_average_checker
// Watches the request and response channels and the block length register,
// keeps its own running sums and pair count, and predicts each block average
// pair. Each accepted response is compared field by field with the oldest
// prediction. The failure and pending counts go to the testbench top.
// ----------------------------------------------------------------------------

module sbad_average_checker #(
   parameter int MAX_BLOCK_LENGTH = sbad_pkg::MAX_BLOCK_LENGTH_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_wr_en,
   input  logic [sbad_pkg::LEN_W-1:0] csr_wr_data,
   sbad_req_if                        req_mon,
   sbad_rsp_if                        rsp_mon,
   output int                         fail_count,
   output int                         pending_count
);
   import sbad_pkg::*;

   localparam int SUM_W        = 28;
   localparam int REPORT_LIMIT = 10;

   typedef struct packed {
      sample_type left;
      sample_type right;
   } avg_pair_type;

   // Predicted averages, oldest first
   avg_pair_type average_queue[$];

   // Shadow of the block state
   logic signed [SUM_W-1:0] left_sum;
   logic signed [SUM_W-1:0] right_sum;
   int unsigned             pair_count;
   logic [LEN_W-1:0]        block_length;
   int                      mismatches;

   // Zero acts as one, anything above capacity acts as capacity
   function automatic int unsigned clamped_length(logic [LEN_W-1:0] raw);
      if (raw == '0) begin
         return 1;
      end
      if (raw > MAX_BLOCK_LENGTH) begin
         return MAX_BLOCK_LENGTH;
      end
      return raw;
   endfunction

   function automatic logic signed [SUM_W-1:0] widen(sample_type s);
      return {{(SUM_W-SAMPLE_W){s[SAMPLE_W-1]}}, s};
   endfunction

   // Signed division truncates toward zero; keep the low 16 bits
   function automatic sample_type truncated_mean(logic signed [SUM_W-1:0] total,
                                                 int unsigned n);
      longint quotient;
      quotient = longint'(total) / longint'(n);
      return quotient[SAMPLE_W-1:0];
   endfunction

   always @(posedge clock) begin : predict_and_compare
      avg_pair_type seen;
      avg_pair_type want;
      int unsigned  span;
      if (reset) begin
         average_queue.delete();
         left_sum     = '0;
         right_sum    = '0;
         pair_count   = 0;
         block_length = LEN_W'(LEN_RESET);
         mismatches   = 0;
      end else begin
         // Check a delivered response against the oldest prediction
         if (rsp_mon.valid && rsp_mon.ready) begin
            seen.left  = rsp_mon.left_average;
            seen.right = rsp_mon.right_average;
            if (average_queue.size() == 0) begin
               mismatches++;
               if (mismatches <= REPORT_LIMIT) begin
                  $display("%0t: response with nothing predicted: left %0d right %0d",
                           $realtime, seen.left, seen.right);
               end
            end else begin
               want = average_queue.pop_front();
               if (seen.left !== want.left || seen.right !== want.right) begin
                  mismatches++;
                  if (mismatches <= REPORT_LIMIT) begin
                     $display("%0t: average mismatch: expected left %0d right %0d,",
                              $realtime, want.left, want.right,
                              " got left %0d right %0d", seen.left, seen.right);
                  end
               end
            end
         end

         // Fold an accepted request into the sums, close the block when due
         if (req_mon.valid && req_mon.ready) begin
            span       = clamped_length(block_length);
            left_sum   = left_sum + widen(req_mon.left_sample);
            right_sum  = right_sum + widen(req_mon.right_sample);
            pair_count = pair_count + 1;
            if (pair_count >= span) begin
               want.left  = truncated_mean(left_sum, pair_count);
               want.right = truncated_mean(right_sum, pair_count);
               average_queue.push_back(want);
               left_sum   = '0;
               right_sum  = '0;
               pair_count = 0;
            end
         end

         // Register writes leave the running block alone
         if (csr_wr_en) begin
            block_length = csr_wr_data;
         end
      end
      fail_count    <= mismatches;
      pending_count <= average_queue.size();
   end

endmodule

// ----- dv/stereo_block_average_decimator_unit_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stereo_block_average_decimator_unit_tb
// Drives stereo sample pairs and block length writes into the decimator,
// with random idling on both channels, and reports the checker's verdict.
// ----------------------------------------------------------------------------

module stereo_block_average_decimator_unit_tb;
   import sbad_pkg::*;

   localparam int         RANDOM_ITEMS  = 420;
   localparam int         SETTLE_CYCLES = 40;
   localparam int         STALL_LIMIT   = 2000;
   localparam int         TAIL_ITEMS    = 40;
   localparam sample_type SAMPLE_MIN    = 16'h8000;
   localparam sample_type SAMPLE_MAX    = 16'h7fff;
   localparam logic [LEN_W-1:0] LEN_TOP = '1;

   logic             clock;
   logic             reset;
   logic             csr_wr_en;
   logic [LEN_W-1:0] csr_wr_data;
   logic             rsp_ready_q  = 1'b0;
   int unsigned      stall_left   = 0;
   int unsigned      quiet_cycles = 0;
   bit               sender_idles;
   bit               receiver_idles;
   int               fail_count;
   int               pending_count;
   int               random_items;
   int               burst;
   logic [LEN_W-1:0] next_length;

   sbad_req_if req_bus ();
   sbad_rsp_if rsp_bus ();

   assign rsp_bus.ready = rsp_ready_q;

   stereo_block_average_decimator_unit dut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_bus     (req_bus),
      .rsp_bus     (rsp_bus)
   );

   sbad_average_checker checker_i (
      .clock         (clock),
      .reset         (reset),
      .csr_wr_en     (csr_wr_en),
      .csr_wr_data   (csr_wr_data),
      .req_mon       (req_bus),
      .rsp_mon       (rsp_bus),
      .fail_count    (fail_count),
      .pending_count (pending_count)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Hold ready low in random bursts while receiver idling is on
   always @(posedge clock) begin
      if (stall_left != 0) begin
         stall_left <= stall_left - 1;
      end else if (receiver_idles && $urandom_range(0, 5) == 0) begin
         rsp_ready_q <= 1'b0;
         stall_left  <= $urandom_range(0, 18);
      end else begin
         rsp_ready_q <= 1'b1;
      end
   end

   // End the run when nothing moves for too long
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == STALL_LIMIT) begin
         $display("end of test: mismatches");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Send one pair, with an optional gap before it
   task automatic push_pair(input sample_type left_value, input sample_type right_value);
      if (sender_idles && $urandom_range(0, 3) == 0) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 19)) @(posedge clock);
      end
      req_bus.valid        <= 1'b1;
      req_bus.left_sample  <= left_value;
      req_bus.right_sample <= right_value;
      do @(posedge clock); while (!req_bus.ready);
   endtask

   // Drop valid, drain all predicted averages, let the block settle
   task automatic drain_requests();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_block_length(input logic [LEN_W-1:0] value);
      drain_requests();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   function automatic sample_type random_sample();
      case ($urandom_range(0, 7))
         0:       return SAMPLE_MIN;
         1:       return SAMPLE_MAX;
         2:       return sample_type'($urandom_range(0, 1) ? -1 : 0);
         default: return sample_type'($urandom);
      endcase
   endfunction

   // Mostly short blocks, now and then zero, one or a longer one
   function automatic logic [LEN_W-1:0] random_block_length();
      case ($urandom_range(0, 9))
         0:       return '0;
         1:       return LEN_W'(1);
         2:       return LEN_W'($urandom_range(17, 48));
         default: return LEN_W'($urandom_range(2, 12));
      endcase
   endfunction

   initial begin
      reset                <= 1'b1;
      csr_wr_en            <= 1'b0;
      csr_wr_data          <= '0;
      req_bus.valid        <= 1'b0;
      req_bus.left_sample  <= '0;
      req_bus.right_sample <= '0;
      sender_idles         <= 1'b0;
      receiver_idles       <= 1'b0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Partial block at the reset length, then shorten it: closes on 4 pairs
      push_pair(SAMPLE_MAX, SAMPLE_MIN);
      push_pair(SAMPLE_MAX, SAMPLE_MIN);
      push_pair(SAMPLE_MIN, SAMPLE_MAX);
      write_block_length(LEN_W'(2));
      push_pair(16'sd0, 16'sd0);

      // Length one passes pairs through
      write_block_length(LEN_W'(1));
      push_pair(SAMPLE_MIN, SAMPLE_MAX);
      push_pair(SAMPLE_MAX, SAMPLE_MIN);
      push_pair(16'sd0, -16'sd1);
      push_pair(-16'sd1, 16'sd0);

      // Length zero acts as one
      write_block_length('0);
      push_pair(16'sd12345, -16'sd12345);
      push_pair(SAMPLE_MIN, SAMPLE_MIN);

      // Truncation toward zero and full-scale averages
      write_block_length(LEN_W'(3));
      push_pair(-16'sd1, 16'sd1);
      push_pair(16'sd0, 16'sd0);
      push_pair(16'sd0, 16'sd0);
      repeat (3) push_pair(SAMPLE_MIN, SAMPLE_MAX);
      write_block_length(LEN_W'(2));
      push_pair(-16'sd3, 16'sd3);
      push_pair(16'sd0, 16'sd0);

      // Length above capacity, then shortened mid-block: closes on 21 pairs
      sender_idles   <= 1'b1;
      receiver_idles <= 1'b1;
      write_block_length(LEN_TOP);
      repeat (20) push_pair(SAMPLE_MIN, SAMPLE_MAX);
      write_block_length(LEN_W'(5));
      push_pair(SAMPLE_MIN, SAMPLE_MAX);

      // Random phases; leftover pairs carry into the next length setting
      random_items = 0;
      while (random_items < RANDOM_ITEMS) begin
         next_length = random_block_length();
         write_block_length(next_length);
         sender_idles   <= ($urandom_range(0, 3) != 0);
         receiver_idles <= ($urandom_range(0, 3) != 0);
         burst = $urandom_range(5, 40);
         repeat (burst) push_pair(random_sample(), random_sample());
         random_items += burst;
      end

      // Closing stretch with no idling
      sender_idles   <= 1'b0;
      receiver_idles <= 1'b0;
      write_block_length(LEN_W'(4));
      repeat (TAIL_ITEMS) push_pair(random_sample(), random_sample());
      drain_requests();

      if (fail_count == 0 && pending_count == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule

// ----- filelist.f -----
rtl/sbad_pkg.sv
rtl/sbad_req_if.sv
rtl/sbad_rsp_if.sv
rtl/sbad_lane.sv
rtl/sbad_merge.sv
rtl/stereo_block_average_decimator_unit.sv
dv/sbad_average_checker.sv
dv/stereo_block_average_decimator_unit_tb.sv
